// ===== rtl/core/mert_pkg.sv =====
// shared types and constants for the masked event rule table
package mert_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_REMOVE = 2'd1;
  localparam logic [1:0] OP_QUERY  = 2'd2;

  localparam int MATCH_TYPE_BIT  = 0;
  localparam int MATCH_CODE_BIT  = 1;
  localparam int MATCH_VALUE_BIT = 2;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [4:0]  event_type;
    logic [9:0]  event_code;
    logic [31:0] event_value;
    logic [31:0] rule_flags;
  } in_item_t;

  typedef struct packed {
    logic        status;
    logic [31:0] found_flags;
  } out_item_t;

  typedef struct packed {
    logic [4:0]       etype;
    logic [9:0]       ecode;
    logic [31:0]      evalue;
    logic [31:0]      eflags;
    logic [IDX_W-1:0] erank;
  } entry_t;

  // compare results for the entry currently on the read port
  typedef struct packed {
    logic key_eq;
    logic full_eq;
    logic mask_eq;
  } match_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FIX,
    ST_WRITE,
    ST_RESP
  } state_t;

endpackage

// ===== rtl/core/mert_entry_ram.sv =====
// single port-pair rule entry memory with registered read
module mert_entry_ram #(
  parameter int DEPTH = 16,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== rtl/core/mert_match.sv =====
// field comparators between the request and the entry read from memory
module mert_match (
  input  mert_pkg::entry_t   ent,
  input  mert_pkg::in_item_t req,
  output mert_pkg::match_t   m
);

  logic type_eq;
  logic code_eq;
  logic value_eq;

  always_comb begin
    type_eq   = (ent.etype == req.event_type);
    code_eq   = (ent.ecode == req.event_code);
    value_eq  = (ent.evalue == req.event_value);
    m.key_eq  = type_eq && code_eq && value_eq;
    m.full_eq = m.key_eq && (ent.eflags == req.rule_flags);
    // a rule with no enable bits matches any event
    m.mask_eq = (!ent.eflags[mert_pkg::MATCH_TYPE_BIT] || type_eq) &&
                (!ent.eflags[mert_pkg::MATCH_CODE_BIT] || code_eq) &&
                (!ent.eflags[mert_pkg::MATCH_VALUE_BIT] || value_eq);
  end

endmodule

// ===== rtl/core/mert_ctrl.sv =====
// sequencer: table walk, rank maintenance, valid bits and result register
module mert_ctrl (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  mert_pkg::in_item_t                 in_item,
  output logic                               out_valid,
  input  logic                               out_stall,
  output mert_pkg::out_item_t                out_item,
  output mert_pkg::in_item_t                 req,
  input  mert_pkg::match_t                   m,
  output logic                               rd_en,
  output logic [mert_pkg::IDX_W-1:0]         rd_addr,
  input  mert_pkg::entry_t                   rd_data,
  output logic                               wr_en,
  output logic [mert_pkg::IDX_W-1:0]         wr_addr,
  output mert_pkg::entry_t                   wr_data
);

  localparam logic [mert_pkg::IDX_W-1:0] LAST_IDX =
    mert_pkg::IDX_W'(mert_pkg::TABLE_DEPTH - 1);

  mert_pkg::state_t state_r, state_nxt;

  mert_pkg::in_item_t  req_r, req_nxt;
  mert_pkg::out_item_t out_item_r, out_item_nxt;
  logic                out_valid_r, out_valid_nxt;

  logic [mert_pkg::TABLE_DEPTH-1:0] valid_r, valid_nxt;

  logic [mert_pkg::IDX_W-1:0] addr_r, addr_nxt;
  logic                       issue_r, issue_nxt;
  logic                       cmp_vld_r, cmp_vld_nxt;
  logic [mert_pkg::IDX_W-1:0] cmp_idx_r, cmp_idx_nxt;

  logic                       hit_r, hit_nxt;
  logic [mert_pkg::IDX_W-1:0] hit_idx_r, hit_idx_nxt;
  logic [mert_pkg::IDX_W-1:0] best_r, best_nxt;
  logic [31:0]                hit_flags_r, hit_flags_nxt;
  logic                       free_r, free_nxt;
  logic [mert_pkg::IDX_W-1:0] free_idx_r, free_idx_nxt;

  logic                       resp_status_r, resp_status_nxt;
  logic [31:0]                resp_flags_r, resp_flags_nxt;

  logic                       ent_vld;
  logic                       walk_last;

  assign in_stall  = (state_r != mert_pkg::ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;
  assign req       = req_r;
  assign rd_addr   = addr_r;

  always_comb begin
    state_nxt       = state_r;
    req_nxt         = req_r;
    out_item_nxt    = out_item_r;
    out_valid_nxt   = out_valid_r;
    valid_nxt       = valid_r;
    addr_nxt        = addr_r;
    issue_nxt       = issue_r;
    hit_nxt         = hit_r;
    hit_idx_nxt     = hit_idx_r;
    best_nxt        = best_r;
    hit_flags_nxt   = hit_flags_r;
    free_nxt        = free_r;
    free_idx_nxt    = free_idx_r;
    resp_status_nxt = resp_status_r;
    resp_flags_nxt  = resp_flags_r;
    rd_en           = 1'b0;
    wr_en           = 1'b0;
    wr_addr         = cmp_idx_r;
    wr_data         = rd_data;
    ent_vld         = valid_r[cmp_idx_r];
    walk_last       = cmp_vld_r && (cmp_idx_r == LAST_IDX);

    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    // read issue shared by the scan and the rank pass
    if ((state_r == mert_pkg::ST_SCAN || state_r == mert_pkg::ST_FIX) && issue_r) begin
      rd_en    = 1'b1;
      addr_nxt = addr_r + mert_pkg::IDX_W'(1);
      if (addr_r == LAST_IDX) begin
        issue_nxt = 1'b0;
      end
    end
    cmp_vld_nxt = rd_en;
    cmp_idx_nxt = addr_r;

    unique case (state_r)
      mert_pkg::ST_IDLE: begin
        if (in_valid) begin
          req_nxt         = in_item;
          hit_nxt         = 1'b0;
          free_nxt        = 1'b0;
          hit_flags_nxt   = '0;
          resp_status_nxt = 1'b0;
          resp_flags_nxt  = '0;
          if (in_item.opcode == mert_pkg::OP_ADD ||
              in_item.opcode == mert_pkg::OP_REMOVE ||
              in_item.opcode == mert_pkg::OP_QUERY) begin
            addr_nxt  = '0;
            issue_nxt = 1'b1;
            state_nxt = mert_pkg::ST_SCAN;
          end else begin
            state_nxt = mert_pkg::ST_RESP;
          end
        end
      end

      mert_pkg::ST_SCAN: begin
        if (cmp_vld_r) begin
          unique case (req_r.opcode)
            mert_pkg::OP_ADD: begin
              if (ent_vld && m.key_eq && !hit_r) begin
                hit_nxt     = 1'b1;
                hit_idx_nxt = cmp_idx_r;
                best_nxt    = rd_data.erank;
              end
              if (!ent_vld && !free_r) begin
                free_nxt     = 1'b1;
                free_idx_nxt = cmp_idx_r;
              end
            end
            mert_pkg::OP_REMOVE: begin
              if (ent_vld && m.full_eq && (!hit_r || rd_data.erank < best_r)) begin
                hit_nxt     = 1'b1;
                hit_idx_nxt = cmp_idx_r;
                best_nxt    = rd_data.erank;
              end
            end
            default: begin
              if (ent_vld && m.mask_eq && (!hit_r || rd_data.erank < best_r)) begin
                hit_nxt       = 1'b1;
                hit_idx_nxt   = cmp_idx_r;
                best_nxt      = rd_data.erank;
                hit_flags_nxt = rd_data.eflags;
              end
            end
          endcase
        end
        if (walk_last) begin
          unique case (req_r.opcode)
            mert_pkg::OP_ADD: begin
              if (hit_nxt) begin
                state_nxt = mert_pkg::ST_WRITE;
              end else if (free_nxt) begin
                addr_nxt  = '0;
                issue_nxt = 1'b1;
                state_nxt = mert_pkg::ST_FIX;
              end else begin
                resp_status_nxt = 1'b1;
                state_nxt       = mert_pkg::ST_RESP;
              end
            end
            mert_pkg::OP_REMOVE: begin
              if (hit_nxt) begin
                valid_nxt[hit_idx_nxt] = 1'b0;
                addr_nxt  = '0;
                issue_nxt = 1'b1;
                state_nxt = mert_pkg::ST_FIX;
              end else begin
                state_nxt = mert_pkg::ST_RESP;
              end
            end
            default: begin
              resp_status_nxt = !hit_nxt;
              resp_flags_nxt  = hit_nxt ? hit_flags_nxt : 32'd0;
              state_nxt       = mert_pkg::ST_RESP;
            end
          endcase
        end
      end

      mert_pkg::ST_FIX: begin
        // add ages every rule, remove pulls older rules one rank newer
        if (cmp_vld_r && ent_vld) begin
          if (req_r.opcode == mert_pkg::OP_ADD) begin
            wr_en         = 1'b1;
            wr_data.erank = rd_data.erank + mert_pkg::IDX_W'(1);
          end else if (rd_data.erank > best_r) begin
            wr_en         = 1'b1;
            wr_data.erank = rd_data.erank - mert_pkg::IDX_W'(1);
          end
        end
        if (walk_last) begin
          state_nxt = (req_r.opcode == mert_pkg::OP_ADD) ? mert_pkg::ST_WRITE
                                                         : mert_pkg::ST_RESP;
        end
      end

      mert_pkg::ST_WRITE: begin
        wr_en          = 1'b1;
        wr_data.etype  = req_r.event_type;
        wr_data.ecode  = req_r.event_code;
        wr_data.evalue = req_r.event_value;
        wr_data.eflags = req_r.rule_flags;
        if (hit_r) begin
          wr_addr       = hit_idx_r;
          wr_data.erank = best_r;
        end else begin
          wr_addr                = free_idx_r;
          wr_data.erank          = '0;
          valid_nxt[free_idx_r]  = 1'b1;
        end
        state_nxt = mert_pkg::ST_RESP;
      end

      mert_pkg::ST_RESP: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt            = 1'b1;
          out_item_nxt.status      = resp_status_r;
          out_item_nxt.found_flags = resp_flags_r;
          state_nxt                = mert_pkg::ST_IDLE;
        end
      end

      default: begin
        state_nxt = mert_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mert_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      valid_r     <= '0;
      issue_r     <= 1'b0;
      cmp_vld_r   <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      valid_r     <= valid_nxt;
      issue_r     <= issue_nxt;
      cmp_vld_r   <= cmp_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_r         <= req_nxt;
    out_item_r    <= out_item_nxt;
    addr_r        <= addr_nxt;
    cmp_idx_r     <= cmp_idx_nxt;
    hit_r         <= hit_nxt;
    hit_idx_r     <= hit_idx_nxt;
    best_r        <= best_nxt;
    hit_flags_r   <= hit_flags_nxt;
    free_r        <= free_nxt;
    free_idx_r    <= free_idx_nxt;
    resp_status_r <= resp_status_nxt;
    resp_flags_r  <= resp_flags_nxt;
  end

endmodule

// ===== rtl/core/masked_event_rule_table.sv =====
// top level of the masked event rule table
//
// Holds up to TABLE_DEPTH (16) interception rules in one entry memory with a
// registered read port; valid bits live in flip-flops and clear at reset, so
// the table is usable right after reset with no clearing pass. One transaction
// is in work at a time and every transaction is answered by one result. The
// time per transaction is set by walking the entry memory one entry a cycle
// through its single read port: a query takes one walk, an add that updates
// an existing rule one walk and a write, an add that places a new rule two
// walks and a write (the second walk ages every rank), a remove that hits
// two walks (the second pulls older ranks newer), and a full table or a
// missed remove one walk. A reserved opcode is answered with no walk. The next
// transaction is taken while the previous result still waits on out_stall.
module masked_event_rule_table (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mert_pkg::in_item_t  in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output mert_pkg::out_item_t out_item
);

  mert_pkg::in_item_t         req;
  mert_pkg::match_t           m;
  mert_pkg::entry_t           rd_data;
  mert_pkg::entry_t           wr_data;
  logic                       rd_en;
  logic                       wr_en;
  logic [mert_pkg::IDX_W-1:0] rd_addr;
  logic [mert_pkg::IDX_W-1:0] wr_addr;
  logic [$bits(mert_pkg::entry_t)-1:0] ram_rdata;

  assign rd_data = ram_rdata;

  mert_entry_ram #(
    .DEPTH (mert_pkg::TABLE_DEPTH),
    .WIDTH ($bits(mert_pkg::entry_t))
  ) u_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (ram_rdata),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  mert_match u_match (
    .ent (rd_data),
    .req (req),
    .m   (m)
  );

  mert_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item),
    .req       (req),
    .m         (m),
    .rd_en     (rd_en),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data)
  );

  // the rank pass writes behind its reads, never onto the entry being read
  a_no_rw_collision: assert property (@(posedge clk) disable iff (!rst_n)
    !(rd_en && wr_en && (rd_addr == wr_addr)))
    else $error("entry memory read and write hit the same entry");

  // one transaction at a time
  a_accept_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("second transaction accepted while one is in work");

  // a result only appears at the end of a transaction in work
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(in_stall))
    else $error("result raised with no transaction in work");

  // memory is only touched while a transaction is in work
  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !(rd_en || wr_en))
    else $error("entry memory accessed while idle");

endmodule
